// File: sv/wds_pkg.sv
// Shared types and constants for the windowed duplicate suppressor.
// No dependencies; the files that use it refer to it by scoped names.
package wds_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 16;
   localparam int KEY_W                 = 32;
   localparam int TIME_W                = 32;
   localparam logic [TIME_W-1:0] WINDOW_RESET = 32'd10;

   // one table entry as held in the entry RAM
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic clear_wr;   // clearing pass: zero the entry at the counter
      logic load_item;  // capture the request and restart the scan
      logic scan_rd;    // read the entry at the counter
      logic commit;     // record the key if allowed and load the response
   } cmd_type;

   typedef struct packed {
      logic cnt_last;   // counter sits on the last table index
      logic rsp_free;   // response register can take a new result
   } status_type;

endpackage

// File: sv/wds_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/wds_datapath.sv
// Datapath: window register, scan counter, entry RAM, match/expiry logic
// and the response register. Depends on wds_pkg and wds_ram.
module wds_datapath #(
   parameter int TABLE_ENTRIES = wds_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  wds_pkg::cmd_type           cmd,
   output wds_pkg::status_type        status,
   input  logic                       csr_write_enable,
   input  logic [wds_pkg::TIME_W-1:0] csr_write_data,
   input  logic [wds_pkg::KEY_W-1:0]  req_message_key,
   input  logic [wds_pkg::TIME_W-1:0] req_arrival_time,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [wds_pkg::KEY_W-1:0]  rsp_echoed_key,
   output logic                       rsp_pass_flag,
   output logic                       rsp_table_overflow
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int ENTRY_W = $bits(wds_pkg::entry_type);

   logic [wds_pkg::TIME_W-1:0] window_ff, window_in;
   logic [IDX_W-1:0]           cnt_ff, cnt_in;
   logic [wds_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [wds_pkg::TIME_W-1:0] now_ff, now_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   logic                       hit_ff, hit_in;
   logic                       free_found_ff, free_found_in;
   logic [IDX_W-1:0]           free_idx_ff, free_idx_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [wds_pkg::KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic                       rsp_pass_ff, rsp_pass_in;
   logic                       rsp_ovf_ff, rsp_ovf_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   wds_pkg::entry_type         wr_entry;
   logic [ENTRY_W-1:0]         rd_data;
   wds_pkg::entry_type         rd_entry;
   logic [wds_pkg::TIME_W:0]   limit;
   logic                       expired;
   logic                       live;

   wds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENTRY_W'(wr_entry)),
      .rd_en   (cmd.scan_rd),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   assign rd_entry = wds_pkg::entry_type'(rd_data);

   // 33-bit expiry sum, no wrap
   always_comb begin
      limit   = {1'b0, rd_entry.stamp} + {1'b0, window_ff};
      expired = rd_entry.valid && (limit < {1'b0, now_ff});
      live    = rd_entry.valid && !expired;
   end

   // write port: clearing pass, expiry write-back, final record
   always_comb begin
      wr_en    = 1'b0;
      wr_addr  = cnt_ff;
      wr_entry = '0;
      if (cmd.clear_wr) begin
         wr_en = 1'b1;
      end else if (rd_pend_ff && expired) begin
         wr_en   = 1'b1;
         wr_addr = rd_idx_ff;
      end else if (cmd.commit && !hit_ff && free_found_ff) begin
         wr_en          = 1'b1;
         wr_addr        = free_idx_ff;
         wr_entry.valid = 1'b1;
         wr_entry.key   = key_ff;
         wr_entry.stamp = now_ff;
      end
   end

   always_comb begin
      window_in     = window_ff;
      cnt_in        = cnt_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      rd_pend_in    = cmd.scan_rd;
      rd_idx_in     = cnt_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pass_in   = rsp_pass_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      if (csr_write_enable) begin
         window_in = csr_write_data;
      end

      if (cmd.load_item) begin
         cnt_in        = '0;
         key_in        = req_message_key;
         now_in        = req_arrival_time;
         hit_in        = 1'b0;
         free_found_in = 1'b0;
      end else if (cmd.clear_wr || cmd.scan_rd) begin
         cnt_in = (cnt_ff == LAST_IDX) ? '0 : cnt_ff + 1'b1;
      end

      if (rd_pend_ff) begin
         if (live && (rd_entry.key == key_ff)) begin
            hit_in = 1'b1;
         end
         if (!live && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = rd_idx_ff;
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_key_in   = key_ff;
         rsp_pass_in  = !hit_ff;
         rsp_ovf_in   = !hit_ff && !free_found_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff     <= wds_pkg::WINDOW_RESET;
         cnt_ff        <= '0;
         rd_pend_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         window_ff     <= window_in;
         cnt_ff        <= cnt_in;
         rd_pend_ff    <= rd_pend_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff      <= key_in;
      now_ff      <= now_in;
      rd_idx_ff   <= rd_idx_in;
      free_idx_ff <= free_idx_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   assign status.cnt_last    = (cnt_ff == LAST_IDX);
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_echoed_key     = rsp_key_ff;
   assign rsp_pass_flag      = rsp_pass_ff;
   assign rsp_table_overflow = rsp_ovf_ff;

endmodule

// File: sv/wds_ctrl.sv
// Controller: sequences the clearing pass, request capture, table scan
// and commit. Depends on wds_pkg.
module wds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wds_pkg::status_type status,
   output wds_pkg::cmd_type    cmd
);

   wds_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wds_pkg::ST_CLEAR: begin
            if (status.cnt_last) state_in = wds_pkg::ST_IDLE;
         end
         wds_pkg::ST_IDLE: begin
            if (req_valid) state_in = wds_pkg::ST_SCAN;
         end
         wds_pkg::ST_SCAN: begin
            if (status.cnt_last) state_in = wds_pkg::ST_DRAIN;
         end
         wds_pkg::ST_DRAIN: begin
            state_in = wds_pkg::ST_COMMIT;
         end
         wds_pkg::ST_COMMIT: begin
            if (status.rsp_free) state_in = wds_pkg::ST_IDLE;
         end
         default: begin
            state_in = wds_pkg::ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         wds_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
         end
         wds_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         wds_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
         end
         wds_pkg::ST_DRAIN: begin
            // last read returns; its result settles this cycle
         end
         wds_pkg::ST_COMMIT: begin
            cmd.commit = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wds_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/windowed_duplicate_suppressor.sv
// Windowed duplicate suppressor: top level joining controller and datapath.
// Each request is scanned against every entry of the entry RAM through its
// single read port, then committed to the response register once it is free;
// no new request is taken until that commit, so one item is handled at a time.
// Reset: window returns to 10, then a clearing pass zeroes the entry RAM;
// no request is taken until it completes.
module windowed_duplicate_suppressor #(
   parameter int TABLE_ENTRIES = wds_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [wds_pkg::TIME_W-1:0] csr_write_data,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [wds_pkg::KEY_W-1:0]  req_message_key,
   input  logic [wds_pkg::TIME_W-1:0] req_arrival_time,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [wds_pkg::KEY_W-1:0]  rsp_echoed_key,
   output logic                       rsp_pass_flag,
   output logic                       rsp_table_overflow
);

   wds_pkg::cmd_type    cmd;
   wds_pkg::status_type status;

   wds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   wds_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_message_key    (req_message_key),
      .req_arrival_time   (req_arrival_time),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_echoed_key     (rsp_echoed_key),
      .rsp_pass_flag      (rsp_pass_flag),
      .rsp_table_overflow (rsp_table_overflow)
   );

   // one item in flight: no second transfer straight after the first
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while an item is in flight");

   // a new response only ever follows a commit
   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

   // overflow is only reported for a passed message
   a_ovf_implies_pass: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pass_flag || !rsp_table_overflow))
      else $error("overflow flagged on a suppressed message");

   // commit never coincides with scan or clearing writes
   a_commit_alone: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!cmd.scan_rd && !cmd.clear_wr && !$past(cmd.scan_rd)))
      else $error("commit overlaps the scan");

endmodule

// File: tb/tb_windowed_duplicate_suppressor.sv
// Testbench for windowed_duplicate_suppressor: directed and random traffic with
// random stalls, checked against an in-bench model of the suppression table.
// Depends on wds_pkg and the windowed_duplicate_suppressor RTL.
`timescale 1ns / 1ps

module tb_windowed_duplicate_suppressor;

   localparam int TABLE_DEPTH = wds_pkg::TABLE_ENTRIES_DEFAULT;
   localparam int KW          = wds_pkg::KEY_W;
   localparam int TW          = wds_pkg::TIME_W;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int SETTLE      = TABLE_DEPTH + 8;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic [KW-1:0] key;
      logic [TW-1:0] arrival;
   } message_type;

   typedef struct packed {
      logic [KW-1:0] key;
      logic          passed;
      logic          overflow;
   } verdict_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_write_enable = 1'b0;
   logic [TW-1:0] csr_write_data = '0;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [KW-1:0] req_message_key = '0;
   logic [TW-1:0] req_arrival_time = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [KW-1:0] rsp_echoed_key;
   logic          rsp_pass_flag;
   logic          rsp_table_overflow;

   // model of the suppression table
   logic [TW-1:0] window_now = wds_pkg::WINDOW_RESET;
   bit            seen_live[TABLE_DEPTH];
   logic [KW-1:0] seen_key[TABLE_DEPTH];
   logic [TW-1:0] seen_stamp[TABLE_DEPTH];

   message_type message_q[$];
   verdict_type verdict_q[$];
   message_type next_msg;
   verdict_type due;
   bit          req_taken = 1'b0;
   bit          steady = 1'b0;
   bit          hold_armed = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   windowed_duplicate_suppressor #(
      .TABLE_ENTRIES (TABLE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message_key    (req_message_key),
      .req_arrival_time   (req_arrival_time),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_echoed_key     (rsp_echoed_key),
      .rsp_pass_flag      (rsp_pass_flag),
      .rsp_table_overflow (rsp_table_overflow)
   );

   always #6 clock = ~clock;

   task automatic flag_mismatch(input string what);
      $display("ERROR: %s", what);
      mismatches++;
   endtask

   // expire stale entries, look the key up, record a new key in the lowest free slot
   function automatic verdict_type judge_message(input logic [KW-1:0] key,
                                                 input logic [TW-1:0] now);
      verdict_type v;
      bit          hit;
      int          free_idx;
      int          i;
      logic [TW:0] horizon;
      hit      = 1'b0;
      free_idx = -1;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         if (seen_live[i]) begin
            horizon = {1'b0, seen_stamp[i]} + {1'b0, window_now};
            if (horizon < {1'b0, now})
               seen_live[i] = 1'b0;
         end
         if (seen_live[i]) begin
            if (seen_key[i] == key)
               hit = 1'b1;
         end else if (free_idx < 0) begin
            free_idx = i;
         end
      end
      v.key      = key;
      v.passed   = !hit;
      v.overflow = 1'b0;
      if (!hit) begin
         if (free_idx >= 0) begin
            seen_live[free_idx]  = 1'b1;
            seen_key[free_idx]   = key;
            seen_stamp[free_idx] = now;
         end else begin
            v.overflow = 1'b1;
         end
      end
      return v;
   endfunction

   // driver: a new item only once the previous one has been transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (message_q.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
            next_msg = message_q[0];
            message_q.delete(0);
            req_valid        <= 1'b1;
            req_message_key  <= next_msg.key;
            req_arrival_time <= next_msg.arrival;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off when armed
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         hold_left  <= 0;
         hold_taken <= 1'b0;
      end else if (hold_armed && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 20);
      end
   end

   // monitor: predict on each request transfer, check on each response transfer
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready)
            verdict_q.insert(verdict_q.size(),
                             judge_message(req_message_key, req_arrival_time));
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               flag_mismatch($sformatf("response for key %08h with none outstanding",
                                       rsp_echoed_key));
            end else begin
               due = verdict_q[0];
               verdict_q.delete(0);
               if (rsp_echoed_key !== due.key)
                  flag_mismatch($sformatf("echoed_key %08h, expected %08h",
                                          rsp_echoed_key, due.key));
               if (rsp_pass_flag !== due.passed)
                  flag_mismatch($sformatf("key %08h: pass_flag %0b, expected %0b",
                                          due.key, rsp_pass_flag, due.passed));
               if (rsp_table_overflow !== due.overflow)
                  flag_mismatch($sformatf("key %08h: table_overflow %0b, expected %0b",
                                          due.key, rsp_table_overflow, due.overflow));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_message(input logic [KW-1:0] key, input logic [TW-1:0] arrival);
      message_type m;
      m.key     = key;
      m.arrival = arrival;
      message_q.insert(message_q.size(), m);
   endtask

   // wait for every transfer to complete, then let the pipeline go quiet
   task automatic drain_and_settle();
      while (message_q.size() != 0 || req_valid || verdict_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_window(input logic [TW-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      window_now = value;
   endtask

   // mostly keys from a small pool with a slowly advancing clock, so that hits,
   // expiries and a full table all occur; the rest is noise
   task automatic queue_traffic(input int count, input int pool_size,
                                input int unsigned step_max);
      logic [KW-1:0] pool[$];
      logic [KW-1:0] key;
      logic [TW-1:0] now;
      logic [TW-1:0] arrival;
      int            n;
      int            r;
      for (n = 0; n < pool_size; n++)
         pool.insert(pool.size(), $urandom);
      now = $urandom;
      for (n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 8)
            key = $urandom;
         else
            key = pool[$urandom_range(pool_size - 1)];
         r = $urandom_range(99);
         if (r < 3) begin
            arrival = now - $urandom_range(0, 4 * step_max + 4);
         end else begin
            if (r < 5)
               now = now + $urandom;
            else
               now = now + $urandom_range(0, step_max);
            arrival = now;
         end
         queue_message(key, arrival);
      end
   endtask

   initial begin
      int i;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset window of 10: boundary of the window, time going backward, full table
      queue_message(32'h0000_0000, 32'd0);
      queue_message(32'hFFFF_FFFF, 32'd0);
      queue_message(32'h0000_0000, 32'd10);
      queue_message(32'h0000_0000, 32'd11);
      queue_message(32'h0000_0000, 32'd5);
      for (i = 0; i <= TABLE_DEPTH; i++)
         queue_message(32'hA5A5_5A00 + i, 32'd100);
      queue_message(32'hA5A5_5A03, 32'd100);
      drain_and_settle();

      // the expiry sum must not wrap at the top of the time range
      program_window(32'h0000_0020);
      queue_message(32'h5A5A_A5A5, 32'hFFFF_FFF0);
      queue_message(32'h5A5A_A5A5, 32'hFFFF_FFFF);
      drain_and_settle();

      program_window(32'h0000_0000);
      queue_traffic(120, 8, 2);
      drain_and_settle();

      steady = 1'b1;
      program_window(32'h0000_0001);
      queue_traffic(120, 12, 2);
      drain_and_settle();
      steady = 1'b0;

      // nothing expires: the table fills and stays full; receiver holds off meanwhile
      program_window(32'hFFFF_FFFF);
      hold_armed = 1'b1;
      queue_traffic(120, 24, 1000);
      drain_and_settle();

      program_window(wds_pkg::WINDOW_RESET);
      queue_traffic(160, 20, 4);
      drain_and_settle();

      program_window($urandom_range(100, 5000));
      queue_traffic(160, 30, window_now / 8);
      drain_and_settle();

      program_window($urandom);
      queue_traffic(160, 20, $urandom_range(1, 1 << 20));
      drain_and_settle();

      program_window(32'd3);
      queue_traffic(140, 16, 3);
      drain_and_settle();

      if (mismatches == 0 && verdict_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
